// ===== rtl/sle_pkg.sv =====
// Shared types and constants for the sequential list engine.
// Depends on nothing; every other file imports it.
package sle_pkg;

	// List storage size
	localparam int CAPACITY = 16;

	// Field widths fixed by the request/response format
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int FIDX_W = 4;
	localparam int CNT_W  = 5;

	// Internal widths that follow from the capacity
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_LOCATE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		func_t                     func;
		logic [POS_W-1:0]          pos;
		logic signed [DATA_W-1:0]  value;
	} sle_req_t;

	typedef struct packed {
		status_t           status;
		logic [FIDX_W-1:0] found_index;
		logic [CNT_W-1:0]  count;
	} sle_rsp_t;

	// Broadcast from the control to every cell of the row
	typedef struct packed {
		logic                      ins;    // accepted insert that will succeed
		logic                      del;    // accepted delete that will succeed
		logic                      acc;    // any accepted request
		logic [CMP_W-1:0]          pos;
		logic [CMP_W-1:0]          len;
		logic [DATA_W-1:0]         value;
	} sle_bus_t;

endpackage

// ===== rtl/sle_cell.sv =====
// One storage cell of the list row: holds one entry and its locate match bit.
// Depends on sle_pkg; instantiated once per list slot by the top level.
module sle_cell
	import sle_pkg::*;
(
	input  logic              clk,
	input  logic [CMP_W-1:0]  idx,
	input  sle_bus_t          bus,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] entry,
	output logic              match
);

	logic [DATA_W-1:0] entry_q;
	logic              match_q;

	// Load, shift up from the left, shift down from the right, or hold
	always_ff @(posedge clk) begin
		if (bus.ins) begin
			if (idx == bus.pos) begin
				entry_q <= bus.value;
			end else if (idx > bus.pos) begin
				entry_q <= left;
			end
		end else if (bus.del) begin
			if (idx >= bus.pos) begin
				entry_q <= right;
			end
		end
	end

	// Compare against the request value, only for slots inside the list
	always_ff @(posedge clk) begin
		if (bus.acc) begin
			match_q <= (idx < bus.len) && (entry_q == bus.value);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== rtl/sle_find.sv =====
// Lowest-set-bit finder over the row of cell match bits.
// Depends on sle_pkg; used by the top level to form the locate index.
module sle_find
	import sle_pkg::*;
(
	input  logic [CAPACITY-1:0] hits,
	output logic                any,
	output logic [IDX_W-1:0]    first
);

	logic [CAPACITY-1:0] below;
	logic [CAPACITY-1:0] lone;

	// Mark whether any lower cell already hit
	always_comb begin
		below[0] = 1'b0;
		for (int k = 1; k < CAPACITY; k++) begin
			below[k] = below[k-1] | hits[k-1];
		end
	end

	assign lone = hits & ~below;

	// Encode the single surviving bit
	always_comb begin
		first = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			first = first | (lone[k] ? IDX_W'(k) : IDX_W'(0));
		end
	end

	assign any = |hits;

endmodule

// ===== rtl/sequential_list_engine.sv =====
// Sequential list engine top level: control, row of list cells, response register.
// Depends on sle_pkg, sle_cell and sle_find.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------
//   request   | start, busy          | req  (func, pos, value)
//   response  | done (one-cycle)     | rsp  (status, found_index, count)
//
// One request per clock cycle while busy is low. Cells shift and compare at the
// accepting edge; the following edge resolves the first matching cell and
// registers the response. busy is high only in the first cycle after reset
// release. The receiver cannot stall: done is a one-cycle strobe.
module sequential_list_engine
	import sle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sle_req_t req,
	output logic     done,
	output sle_rsp_t rsp
);

	logic              busy_q;
	logic              accept;
	logic [LEN_W-1:0]  len_q;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  len_w;
	logic              ins_bad;
	logic              ins_full;
	logic              del_bad;
	sle_bus_t          bus;
	logic [DATA_W-1:0] ent [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic              hit_any;
	logic [IDX_W-1:0]  hit_idx;

	logic              valid_s1;
	logic              locate_s1;
	status_t           status_s1;

	logic              done_q;
	sle_rsp_t          rsp_q;

	assign accept = start && !busy_q;
	assign pos_w  = CMP_W'(req.pos);
	assign len_w  = CMP_W'(len_q);

	// Check the request against the current length
	assign ins_bad  = pos_w > len_w;
	assign ins_full = len_w >= CMP_W'(CAPACITY);
	assign del_bad  = pos_w >= len_w;

	always_comb begin
		bus.acc   = accept;
		bus.ins   = accept && (req.func == FN_INSERT) && !ins_bad && !ins_full;
		bus.del   = accept && (req.func == FN_DELETE) && !del_bad;
		bus.pos   = pos_w;
		bus.len   = len_w;
		bus.value = req.value;
	end

	// Row of cells with neighbour links
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = ent[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = ent[k+1];
		end
		sle_cell u_cell (
			.clk   (clk),
			.idx   (CMP_W'(k)),
			.bus   (bus),
			.left  (left_w),
			.right (right_w),
			.entry (ent[k]),
			.match (hits[k])
		);
	end

	sle_find u_find (
		.hits  (hits),
		.any   (hit_any),
		.first (hit_idx)
	);

	// Hold off requests just after reset; track length and stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			len_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			if (accept) begin
				if (bus.ins) begin
					len_q <= len_q + LEN_W'(1);
				end else if (bus.del) begin
					len_q <= len_q - LEN_W'(1);
				end else if (req.func == FN_CLEAR) begin
					len_q <= '0;
				end
			end
		end
	end

	// Stage 1 payload: status of non-locate requests
	always_ff @(posedge clk) begin
		if (accept) begin
			locate_s1 <= req.func == FN_LOCATE;
			case (req.func)
				FN_INSERT: status_s1 <= ins_bad ? ST_BADPOS : (ins_full ? ST_FULL : ST_OK);
				FN_DELETE: status_s1 <= del_bad ? ST_BADPOS : ST_OK;
				default:   status_s1 <= ST_OK;
			endcase
		end
	end

	// Response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// Response payload: resolve locate result, take length after the request
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.count <= CNT_W'(len_q);
			if (locate_s1) begin
				rsp_q.status      <= hit_any ? ST_OK : ST_NOTFOUND;
				rsp_q.found_index <= hit_any ? FIDX_W'(hit_idx) : '0;
			end else begin
				rsp_q.status      <= status_s1;
				rsp_q.found_index <= '0;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("response strobe missing two cycles after request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("response strobe without a request");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FN_CLEAR) |=> ##1 (rsp.count == '0))
		else $error("clear did not empty the list");

	a_idx_only_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.found_index == '0))
		else $error("found index set on a failed request");
`endif

endmodule
